@@ hw/rtl/ppc_pkg.sv @@
package ppc_pkg;

	// Field and register widths.
	localparam int SAMPLE_W  = 10;
	localparam int REG_W     = 16;
	localparam int LIM_W     = 10;
	localparam int GAIN_FRAC = 8;

	// Derived arithmetic widths.
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int DE_W     = SAMPLE_W + 2;
	localparam int INTEG_W  = LIM_W + 16;
	localparam int MULA_W   = REG_W + DE_W + 1;
	localparam int MULB_W   = REG_W + 1;
	localparam int PROD_W   = MULA_W + MULB_W;
	localparam int ACC_W    = PROD_W + 1;
	localparam int SUM_W    = ACC_W + 17;
	localparam int SUM_FRAC = GAIN_FRAC + 16;
	localparam int QUOT_W   = SUM_W - 1 - SUM_FRAC;

	// Microcode program size.
	localparam int STEP_W = 3;

	// Register reset values.
	localparam logic [REG_W-1:0] GAIN_P_RST   = 16'd7680;
	localparam logic [REG_W-1:0] GAIN_I_RST   = 16'd5120;
	localparam logic [REG_W-1:0] GAIN_D_RST   = 16'd384;
	localparam logic [REG_W-1:0] STEP_RST     = 16'd655;
	localparam logic [REG_W-1:0] INV_STEP_RST = 16'd100;
	localparam logic [LIM_W-1:0] INT_LIM_RST  = 10'd100;
	localparam logic [REG_W-1:0] PWM_MAX_RST  = 16'd4175;
	localparam logic [LIM_W-1:0] CUTOFF_RST   = 10'd10;

	typedef enum logic [2:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_STEP_TIME,
		REG_INV_STEP_TIME,
		REG_INT_LIMIT,
		REG_PWM_MAX,
		REG_CUTOFF
	} reg_idx_t;

	typedef enum logic [1:0] {
		MA_ERR,
		MA_DE,
		MA_INTEG,
		MA_PROD
	} mula_sel_t;

	typedef enum logic [2:0] {
		MB_STEP,
		MB_GP,
		MB_GI,
		MB_GD,
		MB_INV
	} mulb_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef enum logic [1:0] {
		NXT_INC,
		NXT_WAIT_IN,
		NXT_WAIT_OUT
	} nxt_t;

	typedef struct packed {
		logic              accept;
		mula_sel_t         mul_a;
		mulb_sel_t         mul_b;
		logic              prod_en;
		logic              integ_upd;
		acc_op_t           acc_op;
		logic              sum_load;
		logic              out_load;
		nxt_t              nxt;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] target;
		logic [SAMPLE_W-1:0] measured;
	} in_item_t;

	typedef struct packed {
		logic [REG_W-1:0] duty_sat;
		logic [REG_W-1:0] duty_applied;
		logic [REG_W-1:0] compare_value;
	} out_item_t;

	// Control store: one word per step of the tick program.
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		c.mul_a  = MA_ERR;
		c.mul_b  = MB_STEP;
		c.acc_op = ACC_HOLD;
		c.nxt    = NXT_INC;
		unique case (step)
			3'd0: begin
				c.accept = 1'b1;
				c.nxt    = NXT_WAIT_IN;
			end
			3'd1: begin
				c.mul_a   = MA_ERR;
				c.mul_b   = MB_STEP;
				c.prod_en = 1'b1;
			end
			3'd2: begin
				c.integ_upd = 1'b1;
				c.mul_a     = MA_ERR;
				c.mul_b     = MB_GP;
				c.prod_en   = 1'b1;
			end
			3'd3: begin
				c.acc_op  = ACC_LOAD;
				c.mul_a   = MA_DE;
				c.mul_b   = MB_GD;
				c.prod_en = 1'b1;
			end
			3'd4: begin
				c.mul_a   = MA_PROD;
				c.mul_b   = MB_INV;
				c.prod_en = 1'b1;
			end
			3'd5: begin
				c.acc_op  = ACC_ADD;
				c.mul_a   = MA_INTEG;
				c.mul_b   = MB_GI;
				c.prod_en = 1'b1;
			end
			3'd6: begin
				c.sum_load = 1'b1;
			end
			3'd7: begin
				c.out_load = 1'b1;
				c.nxt      = NXT_WAIT_OUT;
				c.target   = '0;
			end
			default: begin
				c.nxt = NXT_INC;
			end
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/ppc_sequencer.sv @@
module ppc_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  ppc_pkg::seq_status_t status,
	output ppc_pkg::ctrl_t      ctrl
);

	logic [ppc_pkg::STEP_W-1:0] step_q;
	logic [ppc_pkg::STEP_W-1:0] step_next;

	assign ctrl = ppc_pkg::ucode(step_q);

	// A waiting step holds the counter until its condition is met.
	always_comb begin
		step_next = step_q;
		unique case (ctrl.nxt)
			ppc_pkg::NXT_INC: step_next = step_q + 1'b1;
			ppc_pkg::NXT_WAIT_IN: begin
				if (status.in_valid) begin
					step_next = step_q + 1'b1;
				end
			end
			ppc_pkg::NXT_WAIT_OUT: begin
				if (status.out_free) begin
					step_next = ctrl.target;
				end
			end
			default: step_next = step_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

@@ hw/rtl/pid_pwm_controller.sv @@
// Channel   Direction  Handshake              Contents
// in        input      in_valid / in_ready    target and measured samples
// out       output     out_valid / out_ready  duty_sat, duty_applied, compare_value
// cfg       input      cfg_we, cfg_idx        cfg_data written to register cfg_idx
//
// Each item runs through an eight-step microcode program, and a new item is taken only
// once the last has run to its end; the shared 29 by 17 bit multiplier is busy on five
// steps. Reset clears the integrator, the previous error, the step counter
// and the output valid flag, and loads every configuration register with its documented
// value. A result waits in the output register; if it has not been taken when the next
// one is ready, the program holds on its last step until the output is free.
module pid_pwm_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ppc_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ppc_pkg::out_item_t          out_data,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_idx,
	input  logic [ppc_pkg::REG_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [ppc_pkg::REG_W-1:0] gain_p_q;
	logic [ppc_pkg::REG_W-1:0] gain_i_q;
	logic [ppc_pkg::REG_W-1:0] gain_d_q;
	logic [ppc_pkg::REG_W-1:0] step_time_q;
	logic [ppc_pkg::REG_W-1:0] inv_step_q;
	logic [ppc_pkg::LIM_W-1:0] int_limit_q;
	logic [ppc_pkg::REG_W-1:0] pwm_max_q;
	logic [ppc_pkg::LIM_W-1:0] cutoff_q;

	// Controller state and per-item working registers.
	logic [ppc_pkg::INTEG_W-1:0]       integ_q;
	logic signed [ppc_pkg::ERR_W-1:0]  prev_err_q;
	logic [ppc_pkg::SAMPLE_W-1:0]      tgt_q;
	logic signed [ppc_pkg::ERR_W-1:0]  err_q;
	logic signed [ppc_pkg::DE_W-1:0]   de_q;
	logic signed [ppc_pkg::PROD_W-1:0] prod_q;
	logic signed [ppc_pkg::ACC_W-1:0]  acc_q;
	logic signed [ppc_pkg::SUM_W-1:0]  sum_q;
	ppc_pkg::out_item_t                out_q;
	logic                              out_valid_q;

	ppc_pkg::ctrl_t       ctrl;
	ppc_pkg::seq_status_t status;
	logic                 in_fire;
	logic                 out_free;
	logic                 out_fire;

	// The sequencer owns the step counter and the control store.
	ppc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign in_ready        = ctrl.accept;
	assign in_fire         = in_valid && in_ready;
	assign out_free        = !out_valid_q || out_ready;
	assign out_fire        = ctrl.out_load && out_free;
	assign status.in_valid = in_valid;
	assign status.out_free = out_free;

	// Configuration writes; narrow registers keep only their low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= ppc_pkg::GAIN_P_RST;
			gain_i_q    <= ppc_pkg::GAIN_I_RST;
			gain_d_q    <= ppc_pkg::GAIN_D_RST;
			step_time_q <= ppc_pkg::STEP_RST;
			inv_step_q  <= ppc_pkg::INV_STEP_RST;
			int_limit_q <= ppc_pkg::INT_LIM_RST;
			pwm_max_q   <= ppc_pkg::PWM_MAX_RST;
			cutoff_q    <= ppc_pkg::CUTOFF_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				ppc_pkg::REG_GAIN_P:        gain_p_q    <= cfg_data;
				ppc_pkg::REG_GAIN_I:        gain_i_q    <= cfg_data;
				ppc_pkg::REG_GAIN_D:        gain_d_q    <= cfg_data;
				ppc_pkg::REG_STEP_TIME:     step_time_q <= cfg_data;
				ppc_pkg::REG_INV_STEP_TIME: inv_step_q  <= cfg_data;
				ppc_pkg::REG_INT_LIMIT:     int_limit_q <= cfg_data[ppc_pkg::LIM_W-1:0];
				ppc_pkg::REG_PWM_MAX:       pwm_max_q   <= cfg_data;
				ppc_pkg::REG_CUTOFF:        cutoff_q    <= cfg_data[ppc_pkg::LIM_W-1:0];
				default:                    gain_p_q    <= gain_p_q;
			endcase
		end
	end

	// Error and error change are formed as the item is taken.
	logic signed [ppc_pkg::ERR_W-1:0] err_next;
	logic signed [ppc_pkg::DE_W-1:0]  de_next;

	assign err_next = signed'(ppc_pkg::ERR_W'(in_data.target))
		- signed'(ppc_pkg::ERR_W'(in_data.measured));
	assign de_next  = ppc_pkg::DE_W'(err_next) - ppc_pkg::DE_W'(prev_err_q);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tgt_q <= in_data.target;
			err_q <= err_next;
			de_q  <= de_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (in_fire) begin
			prev_err_q <= err_next;
		end
	end

	// The shared multiplier. Unsigned operands are zero-extended by one bit so
	// that a single signed multiply covers every product of the tick.
	logic signed [ppc_pkg::MULA_W-1:0] mul_a;
	logic signed [ppc_pkg::MULB_W-1:0] mul_b;
	logic signed [ppc_pkg::PROD_W-1:0] product;

	always_comb begin
		case (ctrl.mul_a)
			ppc_pkg::MA_ERR:   mul_a = ppc_pkg::MULA_W'(err_q);
			ppc_pkg::MA_DE:    mul_a = ppc_pkg::MULA_W'(de_q);
			ppc_pkg::MA_INTEG: mul_a = signed'(ppc_pkg::MULA_W'(integ_q));
			ppc_pkg::MA_PROD:  mul_a = prod_q[ppc_pkg::MULA_W-1:0];
			default:           mul_a = '0;
		endcase
		case (ctrl.mul_b)
			ppc_pkg::MB_STEP: mul_b = signed'({1'b0, step_time_q});
			ppc_pkg::MB_GP:   mul_b = signed'({1'b0, gain_p_q});
			ppc_pkg::MB_GI:   mul_b = signed'({1'b0, gain_i_q});
			ppc_pkg::MB_GD:   mul_b = signed'({1'b0, gain_d_q});
			ppc_pkg::MB_INV:  mul_b = signed'({1'b0, inv_step_q});
			default:          mul_b = '0;
		endcase
	end

	assign product = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (ctrl.prod_en) begin
			prod_q <= product;
		end
	end

	// Integrator: add error times dt, then clamp to zero and the limit in Q.16.
	logic signed [ppc_pkg::ACC_W-1:0] integ_sum;
	logic signed [ppc_pkg::ACC_W-1:0] integ_top;
	logic [ppc_pkg::INTEG_W-1:0]      integ_new;

	assign integ_sum = signed'(ppc_pkg::ACC_W'(integ_q)) + ppc_pkg::ACC_W'(prod_q);
	assign integ_top = signed'(ppc_pkg::ACC_W'({int_limit_q, 16'h0000}));

	always_comb begin
		if (integ_sum[ppc_pkg::ACC_W-1]) begin
			integ_new = '0;
		end else if (integ_sum > integ_top) begin
			integ_new = integ_top[ppc_pkg::INTEG_W-1:0];
		end else begin
			integ_new = integ_sum[ppc_pkg::INTEG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctrl.integ_upd) begin
			integ_q <= integ_new;
		end
	end

	// P and D are gathered in the accumulator; they carry 16 fewer fraction
	// bits than the I term, so they are shifted up when the sum is formed.
	always_ff @(posedge clk) begin
		case (ctrl.acc_op)
			ppc_pkg::ACC_LOAD: acc_q <= ppc_pkg::ACC_W'(prod_q);
			ppc_pkg::ACC_ADD:  acc_q <= acc_q + ppc_pkg::ACC_W'(prod_q);
			default:           acc_q <= acc_q;
		endcase
		if (ctrl.sum_load) begin
			sum_q <= (ppc_pkg::SUM_W'(acc_q) <<< 16) + ppc_pkg::SUM_W'(prod_q);
		end
	end

	// Truncate toward zero and saturate: anything at or below zero gives zero.
	logic                         sum_pos;
	logic [ppc_pkg::QUOT_W-1:0]   quot;
	logic [ppc_pkg::REG_W-1:0]    duty;
	logic [ppc_pkg::REG_W-1:0]    applied;
	ppc_pkg::out_item_t           out_next;

	assign sum_pos = !sum_q[ppc_pkg::SUM_W-1] && (sum_q != '0);
	assign quot    = sum_q[ppc_pkg::SUM_W-2:ppc_pkg::SUM_FRAC];

	always_comb begin
		if (!sum_pos) begin
			duty = '0;
		end else if (quot > ppc_pkg::QUOT_W'(pwm_max_q)) begin
			duty = pwm_max_q;
		end else begin
			duty = quot[ppc_pkg::REG_W-1:0];
		end
	end

	assign applied                = (tgt_q < cutoff_q) ? '0 : duty;
	assign out_next.duty_sat      = duty;
	assign out_next.duty_applied  = applied;
	assign out_next.compare_value = pwm_max_q - applied + 16'd1;

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk) begin
		if (out_fire) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Once an item is taken the program moves on, so no second item follows
	// in the next cycle.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken on two consecutive cycles");

	// The cutoff only ever lowers the duty.
	a_applied_le_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.duty_applied <= out_q.duty_sat))
		else $error("applied duty above saturated duty");

	// The compare word follows from the applied duty and the period.
	a_compare: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.compare_value == pwm_max_q - out_q.duty_applied + 16'd1))
		else $error("compare word inconsistent with applied duty");

	// A new result is only loaded on the last program step, never while the
	// program is waiting for an item.
	a_load_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl.out_load) && !$past(in_ready))
		else $error("result loaded outside the output step");

endmodule

@@ bench/tb_top.sv @@
module tb_top;

	// One control tick waiting to be offered to the block. When hold is set the
	// sender keeps the item back until every earlier result has been taken.
	typedef struct packed {
		logic              hold;
		ppc_pkg::in_item_t sample;
	} tick_t;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	ppc_pkg::in_item_t         in_data   = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	ppc_pkg::out_item_t        out_data;
	logic                      cfg_we    = 1'b0;
	logic [2:0]                cfg_idx   = '0;
	logic [ppc_pkg::REG_W-1:0] cfg_data  = '0;

	// Items still to be offered, and the duty results that accepted items owe.
	tick_t              ticks_pending [$];
	ppc_pkg::out_item_t duty_expected [$];

	// Shadow copy of the configuration registers and of the controller state.
	logic [ppc_pkg::REG_W-1:0] cfg_reg [8];
	longint                    integ_q16 = 0;
	longint                    last_err  = 0;

	int                 send_idle_pct  = 0;
	int                 recv_stall_pct = 0;
	int                 fail_count     = 0;
	ppc_pkg::out_item_t want_item;

	pid_pwm_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// The P and D products are limited before they are scaled up into the
	// format of the sum, so that a huge product cannot overflow the sum.
	function automatic longint sat_widen(input longint x);
		if (x >= (longint'(1) <<< 44)) begin
			return longint'(1) <<< 60;
		end
		if (x <= -(longint'(1) <<< 44)) begin
			return -(longint'(1) <<< 60);
		end
		return x * 65536;
	endfunction

	// Works out the result of one control tick and advances the shadow state.
	// Everything is carried in 64-bit signed arithmetic, which holds every
	// product at these widths without loss.
	function automatic ppc_pkg::out_item_t pid_tick(input ppc_pkg::in_item_t smp);
		longint             tgt, meas, err, top;
		longint             g_p, g_i, g_d, dt, inv, pmax, cut;
		longint             p_term, i_term, d_term, sum, duty, applied, wrap;
		ppc_pkg::out_item_t res;
		tgt  = longint'(smp.target);
		meas = longint'(smp.measured);
		g_p  = longint'(cfg_reg[ppc_pkg::REG_GAIN_P]);
		g_i  = longint'(cfg_reg[ppc_pkg::REG_GAIN_I]);
		g_d  = longint'(cfg_reg[ppc_pkg::REG_GAIN_D]);
		dt   = longint'(cfg_reg[ppc_pkg::REG_STEP_TIME]);
		inv  = longint'(cfg_reg[ppc_pkg::REG_INV_STEP_TIME]);
		top  = longint'(cfg_reg[ppc_pkg::REG_INT_LIMIT]) * 65536;
		pmax = longint'(cfg_reg[ppc_pkg::REG_PWM_MAX]);
		cut  = longint'(cfg_reg[ppc_pkg::REG_CUTOFF]);
		err  = tgt - meas;

		// The integrator is clamped first, and the clamped value feeds the I term
		// of this same tick.
		integ_q16 = integ_q16 + err * dt;
		if (integ_q16 < 0) begin
			integ_q16 = 0;
		end
		if (integ_q16 > top) begin
			integ_q16 = top;
		end

		p_term   = sat_widen(g_p * err);
		i_term   = g_i * integ_q16;
		d_term   = sat_widen(g_d * (err - last_err) * inv);
		last_err = err;

		// Any sum at or below zero, a small negative fraction included, gives zero.
		sum  = p_term + i_term + d_term;
		duty = 0;
		if (sum > 0) begin
			duty = sum >>> ppc_pkg::SUM_FRAC;
			if (duty > pmax) begin
				duty = pmax;
			end
		end
		applied = (tgt < cut) ? 0 : duty;
		wrap    = pmax - applied + 1;

		res.duty_sat      = duty[15:0];
		res.duty_applied  = applied[15:0];
		res.compare_value = wrap[15:0];
		return res;
	endfunction

	// Sender. An item is taken off the queue only when the channel is free, and
	// valid is then held with the payload steady until the block accepts it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				duty_expected.push_back(pid_tick(in_data));
			end
			if (!in_valid || in_ready) begin
				if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle_pct &&
						!(ticks_pending[0].hold && duty_expected.size() != 0)) begin
					in_data  <= ticks_pending[0].sample;
					in_valid <= 1'b1;
					ticks_pending.delete(0);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result taken is checked field by field against the oldest
	// outstanding expectation; the ready line stalls at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (duty_expected.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result: sat %0d applied %0d cmp %0d",
							out_data.duty_sat, out_data.duty_applied, out_data.compare_value);
					end
				end else begin
					want_item = duty_expected.pop_front();
					if (out_data.duty_sat !== want_item.duty_sat ||
							out_data.duty_applied !== want_item.duty_applied ||
							out_data.compare_value !== want_item.compare_value) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"mismatch: expected sat %0d applied %0d cmp %0d, ",
								"got sat %0d applied %0d cmp %0d"},
								want_item.duty_sat, want_item.duty_applied,
								want_item.compare_value, out_data.duty_sat,
								out_data.duty_applied, out_data.compare_value);
						end
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Writes all eight registers, one per cycle, and keeps the shadow copy in
	// step. The two 10-bit registers drop whatever high bits are written.
	task automatic load_regs(input logic [15:0] gp, gi, gd, dt, inv, lim, pmax, cut);
		logic [15:0] vals [8];
		int          i;
		vals = '{gp, gi, gd, dt, inv, lim, pmax, cut};
		for (i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we   <= 1'b1;
			cfg_idx  <= ppc_pkg::reg_idx_t'(i);
			cfg_data <= vals[i];
			if (i == ppc_pkg::REG_INT_LIMIT || i == ppc_pkg::REG_CUTOFF) begin
				cfg_reg[i] = vals[i] & 16'h03FF;
			end else begin
				cfg_reg[i] = vals[i];
			end
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_reg_val();
		case ($urandom_range(7))
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			2, 3: begin
				return 16'($urandom_range(1023));
			end
			default: begin
				return 16'($urandom_range(65535));
			end
		endcase
	endfunction

	task automatic queue_tick(input int t, input int m, input bit hold);
		tick_t tk;
		tk.hold            = hold;
		tk.sample.target   = t[9:0];
		tk.sample.measured = m[9:0];
		ticks_pending.push_back(tk);
	endtask

	// Random ticks: a mix of uniform samples, small errors around the setpoint,
	// setpoints on the cutoff boundary and rail-to-rail extremes, so that the
	// integrator is driven into both clamps as well as wandering between them.
	task automatic queue_random(input int n);
		int j, k, t, m, cut;
		cut = int'(cfg_reg[ppc_pkg::REG_CUTOFF]);
		for (j = 0; j < n; j++) begin
			k = $urandom_range(99);
			t = $urandom_range(1023);
			m = $urandom_range(1023);
			if (k >= 40 && k < 70) begin
				m = t + $urandom_range(16) - 8;
			end else if (k >= 70 && k < 80) begin
				t = cut + $urandom_range(3) - 2;
			end else if (k >= 80) begin
				t = $urandom_range(1) ? 1023 : 0;
				m = $urandom_range(1) ? 1023 : 0;
			end
			t = (t < 0) ? 0 : ((t > 1023) ? 1023 : t);
			m = (m < 0) ? 0 : ((m > 1023) ? 1023 : m);
			queue_tick(t, m, $urandom_range(79) == 0);
		end
	endtask

	// The block is idle once nothing is queued, nothing is offered and nothing
	// is owed; the task then waits on so that its eight-step program can finish.
	task automatic wait_idle();
		while (ticks_pending.size() != 0 || in_valid || duty_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queue_random(n);
		wait_idle();
	endtask

	initial begin
		int ph;
		cfg_reg[ppc_pkg::REG_GAIN_P]        = ppc_pkg::GAIN_P_RST;
		cfg_reg[ppc_pkg::REG_GAIN_I]        = ppc_pkg::GAIN_I_RST;
		cfg_reg[ppc_pkg::REG_GAIN_D]        = ppc_pkg::GAIN_D_RST;
		cfg_reg[ppc_pkg::REG_STEP_TIME]     = ppc_pkg::STEP_RST;
		cfg_reg[ppc_pkg::REG_INV_STEP_TIME] = ppc_pkg::INV_STEP_RST;
		cfg_reg[ppc_pkg::REG_INT_LIMIT]     = ppc_pkg::REG_W'(ppc_pkg::INT_LIM_RST);
		cfg_reg[ppc_pkg::REG_PWM_MAX]       = ppc_pkg::PWM_MAX_RST;
		cfg_reg[ppc_pkg::REG_CUTOFF]        = ppc_pkg::REG_W'(ppc_pkg::CUTOFF_RST);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset configuration: zero and full-scale samples,
		// a run of full positive error to drive the integrator up, a run of full
		// negative error to pull it back down (the derivative swings across its
		// whole range at each reversal), setpoints just below, at and above the
		// cutoff, and errors of either sign, most of them a single step.
		queue_tick(0, 0, 1'b0);
		queue_tick(1023, 1023, 1'b0);
		repeat (6) queue_tick(1023, 0, 1'b0);
		repeat (4) queue_tick(0, 1023, 1'b0);
		queue_tick(9, 0, 1'b1);
		queue_tick(10, 0, 1'b0);
		queue_tick(11, 5, 1'b0);
		queue_tick(512, 511, 1'b0);
		queue_tick(511, 512, 1'b0);
		queue_tick(0, 1, 1'b0);
		queue_tick(1, 0, 1'b0);
		queue_tick(682, 341, 1'b0);
		queue_tick(341, 682, 1'b0);
		queue_tick(1023, 1022, 1'b0);
		run_random(250, 0, 0);

		// Every register at its top. The period of all ones makes the compare
		// word wrap, and the cutoff written as all ones is cut down to 1023.
		load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF);
		run_random(200, 70, 0);

		// A zero tick period freezes the integrator and a zero reciprocal removes
		// the derivative, leaving proportional action on top of a fixed integral.
		load_regs(16'd7680, 16'd5120, 16'd384, 16'd0, 16'd0, 16'd1023, 16'd4175, 16'd0);
		run_random(150, 0, 70);

		// A zero period forces the duty to zero and the compare word to one.
		load_regs(16'd2000, 16'd3000, 16'd500, 16'd655, 16'd1, 16'd0, 16'd0, 16'd0);
		run_random(60, 19, 19);

		// Random settings, with the phases cycling through four patterns of idling.
		for (ph = 0; ph < 5; ph++) begin
			load_regs(rand_reg_val(), rand_reg_val(), rand_reg_val(), rand_reg_val(),
				rand_reg_val(), rand_reg_val(), rand_reg_val(), rand_reg_val());
			case (ph % 4)
				0: begin
					run_random(220, 0, 0);
				end
				1: begin
					run_random(220, 70, 0);
				end
				2: begin
					run_random(220, 0, 70);
				end
				default: begin
					run_random(220, 19, 19);
				end
			endcase
		end

		if (fail_count == 0 && duty_expected.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin
		#10000000;
		$display("FAILURE");
		$finish;
	end

endmodule
